// File: hw/rtl/pti_pkg.sv
// Shared types, constants and helpers for the pilot time-direction interpolator.
// Used by pilot_time_linear_interpolator_core; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package pti_pkg;

  // Field widths
  localparam int VAL_W    = 32;          // Q16.16 value
  localparam int SLOPE_W  = VAL_W + 1;   // exact slope of a 33-bit difference
  localparam int WIDE_W   = 39;          // headroom for base +/- dist * slope
  localparam int DIST_W   = 5;           // 4-bit distance plus sign bit
  localparam int CNT_W    = 3;           // pilot counts
  localparam int POS_W    = 4;           // symbol positions
  localparam int POS_IW   = 2;           // index into the four position registers
  localparam int NUM_POS  = 4;
  localparam int SC_W     = 5;           // symbol counter / symbol_count
  localparam int SIDX_W   = 4;           // symbol_index field
  localparam int OUT_TDATA_W = 40;       // symbol_index + interp_value, byte padded
  localparam int OUT_PAD_W   = OUT_TDATA_W - SIDX_W - VAL_W;

  // Slope divider: one quotient bit per cycle over the 32-bit magnitude
  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // Sizing defaults
  localparam int MAX_PILOTS_DEF = 4;
  localparam int MAX_SYMBOLS    = 16;
  localparam int SYM_LIMIT      = (MAX_SYMBOLS < 16) ? MAX_SYMBOLS : 16;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 5;
  localparam logic [CFG_AW-1:0] REG_PILOT_COUNT  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_POS_A        = 3'd1;
  localparam logic [CFG_AW-1:0] REG_POS_B        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_POS_C        = 3'd3;
  localparam logic [CFG_AW-1:0] REG_POS_D        = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SYMBOL_COUNT = 3'd5;

  // Register reset values
  localparam logic [CNT_W-1:0] DEF_PILOT_COUNT  = 3'd2;
  localparam logic [POS_W-1:0] DEF_POS_A        = 4'd3;
  localparam logic [POS_W-1:0] DEF_POS_B        = 4'd10;
  localparam logic [POS_W-1:0] DEF_POS_C        = 4'd12;
  localparam logic [POS_W-1:0] DEF_POS_D        = 4'd14;
  localparam logic [SC_W-1:0]  DEF_SYMBOL_COUNT = 5'd14;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_DIV_SETUP,
    S_DIV,
    S_SLOPE,
    S_EMIT,
    S_ERR
  } pti_state_t;

  // Clamp a wide signed value into the 32-bit Q16.16 range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic in_range;
    in_range = (&v[WIDE_W-1:VAL_W-1]) || !(|v[WIDE_W-1:VAL_W-1]);
    if (in_range) begin
      sat_val = v[VAL_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pti_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/pilot_time_linear_interpolator_core.sv
// Pilot time-direction linear interpolator: top level, sequencer and datapath.
// Depends on pti_pkg (types, constants, saturation) and pti_ram (pilot store).
// Flow: an item that does not close a carrier is stored while idle. The closing item
//   starts slope work for each segment (two reads, setup, 32 divider steps, write-back;
//   n-1 segments for n = pilots in use), then one result per cycle unless m_tready stalls.
// A new carrier is taken only after the last result of the previous one; the
//   shared one-bit-per-cycle divider dominates the time. Input ready only while idle.
// Reset: synchronous, active high; config registers return to defaults, received-pilot count clears.
`timescale 1ns / 1ps
`default_nettype none

module pilot_time_linear_interpolator_core #(
  parameter int MAX_PILOTS = pti_pkg::MAX_PILOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input items
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [pti_pkg::VAL_W-1:0]         s_tdata,   // [31:0] pilot_value
  // result items
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [pti_pkg::OUT_TDATA_W-1:0]        m_tdata,   // [3:0] symbol_index,
                                                            // [35:4] interp_value, 0 pad
  output logic                                   m_tlast,   // last_of_run
  output logic                                   m_tuser,   // config_error
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [pti_pkg::CFG_AW-1:0]        cfg_addr,
  input  wire logic [pti_pkg::CFG_DW-1:0]        cfg_data
);

  localparam int PA_W     = (MAX_PILOTS > 1) ? $clog2(MAX_PILOTS) : 1;
  localparam int SL_DEPTH = MAX_PILOTS - 1;
  localparam int SL_W     = (SL_DEPTH > 1) ? $clog2(SL_DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [pti_pkg::CNT_W-1:0] pilot_count;
  logic [pti_pkg::POS_W-1:0] pos [pti_pkg::NUM_POS];
  logic [pti_pkg::SC_W-1:0]  symbol_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pilot_count  <= pti_pkg::DEF_PILOT_COUNT;
      pos[0]       <= pti_pkg::DEF_POS_A;
      pos[1]       <= pti_pkg::DEF_POS_B;
      pos[2]       <= pti_pkg::DEF_POS_C;
      pos[3]       <= pti_pkg::DEF_POS_D;
      symbol_count <= pti_pkg::DEF_SYMBOL_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pti_pkg::REG_PILOT_COUNT:  pilot_count  <= cfg_data[pti_pkg::CNT_W-1:0];
        pti_pkg::REG_POS_A:        pos[0]       <= cfg_data[pti_pkg::POS_W-1:0];
        pti_pkg::REG_POS_B:        pos[1]       <= cfg_data[pti_pkg::POS_W-1:0];
        pti_pkg::REG_POS_C:        pos[2]       <= cfg_data[pti_pkg::POS_W-1:0];
        pti_pkg::REG_POS_D:        pos[3]       <= cfg_data[pti_pkg::POS_W-1:0];
        pti_pkg::REG_SYMBOL_COUNT: symbol_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pilots in use and configuration check
  logic [pti_pkg::CNT_W-1:0] n_used;
  logic                      cfg_ok;

  always_comb begin
    if (pilot_count < 3'd2) begin
      n_used = 3'd2;
    end else if (pilot_count > pti_pkg::CNT_W'(MAX_PILOTS)) begin
      n_used = pti_pkg::CNT_W'(MAX_PILOTS);
    end else begin
      n_used = pilot_count;
    end

    cfg_ok = 1'b1;
    if (pilot_count < 3'd2 || pilot_count > pti_pkg::CNT_W'(MAX_PILOTS)) begin
      cfg_ok = 1'b0;
    end
    if (symbol_count < 5'd2 || symbol_count > pti_pkg::SC_W'(pti_pkg::SYM_LIMIT)) begin
      cfg_ok = 1'b0;
    end
    for (int t = 0; t < pti_pkg::NUM_POS - 1; t++) begin
      if (pti_pkg::CNT_W'(t + 1) < n_used && pos[t + 1] <= pos[t]) begin
        cfg_ok = 1'b0;
      end
    end
    if ({1'b0, pos[pti_pkg::POS_IW'(n_used - 3'd1)]} >= symbol_count) begin
      cfg_ok = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // State and datapath registers
  pti_pkg::pti_state_t state, state_next;

  logic [pti_pkg::CNT_W-1:0]          rcvd;       // pilots of this carrier so far
  logic [PA_W-1:0]                    k;          // segment whose slope is computed
  logic signed [pti_pkg::VAL_W-1:0]   lo_val;     // pilot k
  logic                               div_neg;
  logic [pti_pkg::VAL_W-1:0]          div_quo;    // dividend shifts out, quotient in
  logic [pti_pkg::POS_W-1:0]          div_rem;
  logic [pti_pkg::DIV_CW-1:0]         div_cnt;
  logic signed [pti_pkg::SLOPE_W-1:0] slope [SL_DEPTH];
  logic [pti_pkg::SC_W-1:0]           s_cnt;      // symbol being emitted
  logic [pti_pkg::CNT_W-1:0]          nxt;        // pilots already passed
  logic signed [pti_pkg::VAL_W-1:0]   prev;

  // Pilot store
  logic [PA_W-1:0]           rd_addr;
  logic [pti_pkg::VAL_W-1:0] rd_data;
  logic                      st_we;

  logic in_fire;
  logic closes;
  logic out_free;
  logic out_load;

  assign in_fire  = s_tvalid && s_tready;
  assign closes   = (rcvd + 3'd1) >= n_used;
  assign out_free = !m_tvalid || m_tready;
  assign st_we    = in_fire && (rcvd < pti_pkg::CNT_W'(MAX_PILOTS));

  pti_ram #(
    .WIDTH (pti_pkg::VAL_W),
    .DEPTH (MAX_PILOTS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (PA_W'(rcvd)),
    .wdata (s_tdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Slope datapath: difference, gap and one divider step
  logic [PA_W-1:0]                  k1;
  logic [pti_pkg::POS_W-1:0]        div_gap;
  logic signed [pti_pkg::SLOPE_W-1:0] diff;
  logic [pti_pkg::POS_W:0]          div_shift;
  logic                             div_ge;
  logic signed [pti_pkg::SLOPE_W-1:0] slope_res;

  always_comb begin
    k1        = k + PA_W'(1);
    div_gap   = pos[pti_pkg::POS_IW'(k1)] - pos[pti_pkg::POS_IW'(k)];
    diff      = pti_pkg::SLOPE_W'($signed(rd_data)) - pti_pkg::SLOPE_W'(lo_val);
    div_shift = {div_rem, div_quo[pti_pkg::VAL_W-1]};
    div_ge    = div_shift >= {1'b0, div_gap};
    slope_res = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  end

  // ---------------------------------------------------------------------------
  // Output value datapath
  logic                               is_pilot;
  logic                               emit_last;
  logic [pti_pkg::POS_W-1:0]          lead_gap;
  logic signed [pti_pkg::DIST_W-1:0]  lead_gap_s;
  logic signed [pti_pkg::WIDE_W-2:0]  prod;
  logic signed [pti_pkg::WIDE_W-1:0]  first_v;
  logic signed [pti_pkg::WIDE_W-1:0]  step_v;
  logic [pti_pkg::CNT_W-1:0]          sidx_raw;
  logic [pti_pkg::CNT_W-1:0]          sidx_lim;
  logic [SL_W-1:0]                    sidx;
  logic signed [pti_pkg::VAL_W-1:0]   emit_val;

  always_comb begin
    is_pilot  = (nxt < n_used) &&
                (s_cnt == {1'b0, pos[pti_pkg::POS_IW'(nxt)]});
    emit_last = (s_cnt + 5'd1) == symbol_count;
    // before the first pilot: p0 - distance * slope0
    lead_gap   = pos[0] - s_cnt[pti_pkg::POS_W-1:0];
    lead_gap_s = $signed({1'b0, lead_gap});
    prod       = slope[0] * lead_gap_s;
    first_v   = pti_pkg::WIDE_W'($signed(rd_data)) - pti_pkg::WIDE_W'(prod);
    // later symbols: previous output plus current (or last) slope
    sidx_raw  = nxt - 3'd1;
    sidx_lim  = n_used - 3'd2;
    sidx      = SL_W'((sidx_raw > sidx_lim) ? sidx_lim : sidx_raw);
    step_v    = pti_pkg::WIDE_W'(prev) + pti_pkg::WIDE_W'(slope[sidx]);
    if (is_pilot) begin
      emit_val = $signed(rd_data);
    end else if (nxt == 3'd0) begin
      emit_val = pti_pkg::sat_val(first_v);
    end else begin
      emit_val = pti_pkg::sat_val(step_v);
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pti_pkg::S_IDLE: begin
        if (in_fire && closes) begin
          state_next = cfg_ok ? pti_pkg::S_RD_LO : pti_pkg::S_ERR;
        end
      end
      pti_pkg::S_RD_LO:     state_next = pti_pkg::S_RD_HI;
      pti_pkg::S_RD_HI:     state_next = pti_pkg::S_DIV_SETUP;
      pti_pkg::S_DIV_SETUP: state_next = pti_pkg::S_DIV;
      pti_pkg::S_DIV: begin
        if (div_cnt == pti_pkg::DIV_CW'(pti_pkg::DIV_STEPS - 1)) begin
          state_next = pti_pkg::S_SLOPE;
        end
      end
      pti_pkg::S_SLOPE: begin
        state_next = (pti_pkg::CNT_W'(k1) + 3'd1 >= n_used) ? pti_pkg::S_EMIT
                                                            : pti_pkg::S_RD_LO;
      end
      pti_pkg::S_EMIT: begin
        if (out_free && emit_last) state_next = pti_pkg::S_IDLE;
      end
      pti_pkg::S_ERR: begin
        if (out_free) state_next = pti_pkg::S_IDLE;
      end
      default:     state_next = pti_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    rd_addr  = '0;
    unique case (state)
      pti_pkg::S_IDLE:  s_tready = 1'b1;
      pti_pkg::S_RD_LO: rd_addr  = k;
      pti_pkg::S_RD_HI: rd_addr  = k1;
      pti_pkg::S_EMIT: begin
        out_load = out_free;
        // keep the store read one step ahead of the pilot pointer
        rd_addr  = (out_free && is_pilot) ? PA_W'(nxt + 3'd1) : PA_W'(nxt);
      end
      pti_pkg::S_ERR:   out_load = out_free;
      default: rd_addr  = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pti_pkg::S_IDLE;
      rcvd     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        rcvd <= closes ? '0 : rcvd + 3'd1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      pti_pkg::S_IDLE: begin
        k <= '0;
      end
      pti_pkg::S_RD_HI: begin
        lo_val <= $signed(rd_data);
      end
      pti_pkg::S_DIV_SETUP: begin
        div_neg <= diff[pti_pkg::SLOPE_W-1];
        div_quo <= diff[pti_pkg::SLOPE_W-1] ? pti_pkg::VAL_W'(-diff)
                                            : diff[pti_pkg::VAL_W-1:0];
        div_rem <= '0;
        div_cnt <= '0;
      end
      pti_pkg::S_DIV: begin
        div_rem <= div_ge ? pti_pkg::POS_W'(div_shift - {1'b0, div_gap})
                          : div_shift[pti_pkg::POS_W-1:0];
        div_quo <= {div_quo[pti_pkg::VAL_W-2:0], div_ge};
        div_cnt <= div_cnt + pti_pkg::DIV_CW'(1);
      end
      pti_pkg::S_SLOPE: begin
        slope[SL_W'(k)] <= slope_res;
        k     <= k1;
        s_cnt <= '0;
        nxt   <= '0;
      end
      pti_pkg::S_EMIT: begin
        if (out_load) begin
          prev    <= emit_val;
          s_cnt   <= s_cnt + 5'd1;
          m_tdata <= {{pti_pkg::OUT_PAD_W{1'b0}}, emit_val,
                      s_cnt[pti_pkg::SIDX_W-1:0]};
          m_tlast <= emit_last;
          m_tuser <= 1'b0;
          if (is_pilot) begin
            nxt <= nxt + 3'd1;
          end
        end
      end
      pti_pkg::S_ERR: begin
        if (out_load) begin
          m_tdata <= '0;
          m_tlast <= 1'b1;
          m_tuser <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // received-pilot count never runs past the store
  a_rcvd_range: assert property (@(posedge clk) disable iff (rst)
    rcvd < pti_pkg::CNT_W'(MAX_PILOTS))
    else $error("pilot count beyond store depth");

  // divider remainder stays below the gap
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == pti_pkg::S_DIV) |-> (div_rem < div_gap))
    else $error("divider remainder out of range");

  // pilot pointer bounded while emitting
  a_nxt_range: assert property (@(posedge clk) disable iff (rst)
    (state == pti_pkg::S_EMIT) |-> (nxt <= n_used))
    else $error("pilot pointer beyond pilots in use");

  // every pilot has been passed when a carrier ends
  a_all_pilots: assert property (@(posedge clk) disable iff (rst)
    (state == pti_pkg::S_EMIT && out_load && emit_last) |=>
      (state == pti_pkg::S_IDLE && nxt == n_used))
    else $error("carrier ended before all pilots were passed");

  // an error item is a lone zero result closing the carrier
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
    else $error("malformed error item");
`endif

endmodule

`default_nettype wire
